/* design/trmx_pkg.sv */
// Shared types and constants for the tiny register machine execute block.
// No dependencies; every other design file refers to this package by scoped names.
package trmx_pkg;

    localparam int REG_WIDTH  = 32;
    localparam int PROG_DEPTH = 256;
    localparam int PC_W       = 32;
    localparam int PLEN_W     = 9;
    localparam int STEP_W     = 8;
    localparam int IMM_W      = 31;
    localparam int SHAMT_W    = $clog2(REG_WIDTH);
    localparam int STEP_LIMIT_RESET = 150;

    typedef enum logic [3:0] {
        OP_NOP = 4'd0,
        OP_SET = 4'd1,
        OP_AND = 4'd2,
        OP_OR  = 4'd3,
        OP_ADD = 4'd4,
        OP_SUB = 4'd5,
        OP_SHL = 4'd6,
        OP_SHR = 4'd7,
        OP_JMP = 4'd8,
        OP_PRT = 4'd9,
        OP_CMT = 4'd10
    } opcode_t;

    typedef enum logic [2:0] {
        K_BAD,
        K_NOP,
        K_WRITE,
        K_JMP,
        K_PRT
    } kind_t;

    typedef enum logic [2:0] {
        ALU_SET,
        ALU_AND,
        ALU_OR,
        ALU_ADD,
        ALU_SUB,
        ALU_SHL,
        ALU_SHR
    } alu_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MALFORMED = 2'd1,
        ERR_STEPS     = 2'd2,
        ERR_HALTED    = 2'd3
    } err_t;

    localparam logic [2:0] ADDR_PROG_LENGTH = 3'd0;
    localparam logic [2:0] ADDR_STEP_LIMIT  = 3'd4;

    typedef struct packed {
        kind_t              kind;
        alu_t               alu;
        logic [1:0]         dest_reg;
        logic               src_is_reg;
        logic [1:0]         src_reg;
        logic [IMM_W-1:0]   src_imm;
    } instr_t;

    typedef struct packed {
        logic [PLEN_W-1:0]  program_length;
        logic [STEP_W-1:0]  step_limit;
    } cfg_t;

    typedef struct packed {
        logic [PC_W-1:0]      next_pc;
        logic                 prog_done;
        logic                 print_valid;
        logic                 print_from_reg;
        logic [1:0]           print_reg;
        logic [REG_WIDTH-1:0] print_value;
        err_t                 error_code;
    } result_t;

endpackage

/* design/trmx_if.sv */
// Handshake channel interfaces for instruction items and result items.
// Depends on trmx_pkg for field widths.
interface trmx_req_if;
    logic                        valid;
    logic                        ready;
    logic [3:0]                  req_type;
    logic                        malformed;
    logic [1:0]                  dest_reg;
    logic                        src_is_reg;
    logic [1:0]                  src_reg;
    logic [trmx_pkg::IMM_W-1:0]  src_imm;

    modport source (output valid, req_type, malformed, dest_reg, src_is_reg, src_reg, src_imm,
                    input ready);
    modport sink   (input valid, req_type, malformed, dest_reg, src_is_reg, src_reg, src_imm,
                    output ready);
endinterface

interface trmx_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [trmx_pkg::PC_W-1:0]       next_pc;
    logic                            prog_done;
    logic                            print_valid;
    logic                            print_from_reg;
    logic [1:0]                      print_reg;
    logic [trmx_pkg::REG_WIDTH-1:0]  print_value;
    logic [1:0]                      error_code;

    modport source (output valid, next_pc, prog_done, print_valid, print_from_reg, print_reg,
                    print_value, error_code, input ready);
    modport sink   (input valid, next_pc, prog_done, print_valid, print_from_reg, print_reg,
                    print_value, error_code, output ready);
endinterface

/* design/trmx_cfg.sv */
// APB-style configuration registers: program length and step limit.
// Depends on trmx_pkg.
module trmx_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output trmx_pkg::cfg_t       cfg
);

    trmx_pkg::cfg_t cfg_reg;
    trmx_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            if (paddr[2] == trmx_pkg::ADDR_STEP_LIMIT[2])
                cfg_next.step_limit = pwdata[trmx_pkg::STEP_W-1:0];
            else
                cfg_next.program_length = pwdata[trmx_pkg::PLEN_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == trmx_pkg::ADDR_STEP_LIMIT[2])
            prdata = 32'(cfg_reg.step_limit);
        else
            prdata = 32'(cfg_reg.program_length);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.program_length <= '0;
            cfg_reg.step_limit     <= trmx_pkg::STEP_W'(trmx_pkg::STEP_LIMIT_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/trmx_front.sv */
// Front end: takes instruction beats and classifies them into decoded entries.
// Depends on trmx_pkg and trmx_req_if.
module trmx_front (
    trmx_req_if.sink            req,
    input  logic                q_full,
    output logic                q_push,
    output trmx_pkg::instr_t    q_data
);

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    always_comb
    begin
        q_data.alu        = trmx_pkg::ALU_SET;
        q_data.dest_reg   = req.dest_reg;
        q_data.src_is_reg = req.src_is_reg;
        q_data.src_reg    = req.src_reg;
        q_data.src_imm    = req.src_imm;
        unique case (req.req_type)
            trmx_pkg::OP_NOP, trmx_pkg::OP_CMT: q_data.kind = trmx_pkg::K_NOP;
            trmx_pkg::OP_SET:
            begin
                q_data.kind = trmx_pkg::K_WRITE;
                q_data.alu  = trmx_pkg::ALU_SET;
            end
            trmx_pkg::OP_AND:
            begin
                q_data.kind = trmx_pkg::K_WRITE;
                q_data.alu  = trmx_pkg::ALU_AND;
            end
            trmx_pkg::OP_OR:
            begin
                q_data.kind = trmx_pkg::K_WRITE;
                q_data.alu  = trmx_pkg::ALU_OR;
            end
            trmx_pkg::OP_ADD:
            begin
                q_data.kind = trmx_pkg::K_WRITE;
                q_data.alu  = trmx_pkg::ALU_ADD;
            end
            trmx_pkg::OP_SUB:
            begin
                q_data.kind = trmx_pkg::K_WRITE;
                q_data.alu  = trmx_pkg::ALU_SUB;
            end
            trmx_pkg::OP_SHL:
            begin
                q_data.kind = trmx_pkg::K_WRITE;
                q_data.alu  = trmx_pkg::ALU_SHL;
            end
            trmx_pkg::OP_SHR:
            begin
                q_data.kind = trmx_pkg::K_WRITE;
                q_data.alu  = trmx_pkg::ALU_SHR;
            end
            trmx_pkg::OP_JMP: q_data.kind = trmx_pkg::K_JMP;
            trmx_pkg::OP_PRT: q_data.kind = trmx_pkg::K_PRT;
            default:          q_data.kind = trmx_pkg::K_BAD;
        endcase
        if (req.malformed)
            q_data.kind = trmx_pkg::K_BAD;
    end

endmodule

/* design/trmx_queue.sv */
// Two-entry queue of decoded instructions between front and back end.
// Depends on trmx_pkg.
module trmx_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  trmx_pkg::instr_t    push_data,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output trmx_pkg::instr_t    pop_data
);

    trmx_pkg::instr_t mem [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full     = count_reg == 2'd2;
    assign valid    = count_reg != 2'd0;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/trmx_back.sv */
// Back end: register file, program counter, step count and halt; one entry per cycle
// into a result register unless rsp stalls it. Depends on trmx_pkg and trmx_rsp_if.
module trmx_back (
    input  logic                clk,
    input  logic                rst_n,
    input  trmx_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  trmx_pkg::instr_t    q_data,
    output logic                q_pop,
    trmx_rsp_if.source          rsp
);

    localparam int RW = trmx_pkg::REG_WIDTH;

    logic [RW-1:0]                 rf_reg [4];
    logic [RW-1:0]                 rf_next [4];
    logic [trmx_pkg::PC_W-1:0]     pc_reg;
    logic [trmx_pkg::PC_W-1:0]     pc_next;
    logic [trmx_pkg::STEP_W-1:0]   steps_reg;
    logic [trmx_pkg::STEP_W-1:0]   steps_next;
    logic                          halted_reg;
    logic                          halted_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    trmx_pkg::result_t             res_reg;
    trmx_pkg::result_t             res_next;

    logic [RW-1:0]                 operand;
    logic [RW-1:0]                 dval;
    logic [RW-1:0]                 alu_out;
    logic                          shamt_big;
    logic [trmx_pkg::PC_W-1:0]     limit_len;

    assign operand   = q_data.src_is_reg ? rf_reg[q_data.src_reg] : RW'(q_data.src_imm);
    assign dval      = rf_reg[q_data.dest_reg];
    assign shamt_big = operand >= RW'(RW);
    assign q_pop     = q_valid && (!out_valid_reg || rsp.ready);
    assign limit_len = (32'(cfg.program_length) < 32'(trmx_pkg::PROG_DEPTH))
                       ? 32'(cfg.program_length) : 32'(trmx_pkg::PROG_DEPTH);

    always_comb
    begin
        unique case (q_data.alu)
            trmx_pkg::ALU_SET: alu_out = operand;
            trmx_pkg::ALU_AND: alu_out = dval & operand;
            trmx_pkg::ALU_OR:  alu_out = dval | operand;
            trmx_pkg::ALU_ADD: alu_out = dval + operand;
            trmx_pkg::ALU_SUB: alu_out = dval - operand;
            trmx_pkg::ALU_SHL: alu_out = shamt_big ? '0
                                         : dval << operand[trmx_pkg::SHAMT_W-1:0];
            trmx_pkg::ALU_SHR: alu_out = shamt_big ? '0
                                         : dval >> operand[trmx_pkg::SHAMT_W-1:0];
            default:           alu_out = operand;
        endcase
    end

    always_comb
    begin
        rf_next        = rf_reg;
        pc_next        = pc_reg;
        steps_next     = steps_reg;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        res_next       = res_reg;

        if (q_pop)
        begin
            out_valid_next          = 1'b1;
            res_next.print_valid    = 1'b0;
            res_next.print_from_reg = 1'b0;
            res_next.print_reg      = 2'd0;
            res_next.print_value    = '0;
            res_next.error_code     = trmx_pkg::ERR_NONE;
            priority if (halted_reg)
            begin
                res_next.error_code = trmx_pkg::ERR_HALTED;
            end
            else if (q_data.kind == trmx_pkg::K_BAD)
            begin
                res_next.error_code = trmx_pkg::ERR_MALFORMED;
                halted_next         = 1'b1;
            end
            else
            begin
                if (q_data.kind == trmx_pkg::K_WRITE)
                    rf_next[q_data.dest_reg] = alu_out;
                if (q_data.kind == trmx_pkg::K_JMP && rf_reg[3] == '0)
                    pc_next = 32'(operand);
                else
                    pc_next = pc_reg + 32'd1;
                if (q_data.kind == trmx_pkg::K_PRT)
                begin
                    res_next.print_valid    = 1'b1;
                    res_next.print_from_reg = q_data.src_is_reg;
                    res_next.print_reg      = q_data.src_is_reg ? q_data.src_reg : 2'd0;
                    res_next.print_value    = operand;
                end
                if (steps_reg >= cfg.step_limit)
                begin
                    res_next.error_code = trmx_pkg::ERR_STEPS;
                    halted_next         = 1'b1;
                end
                if (steps_reg != '1)
                    steps_next = steps_reg + trmx_pkg::STEP_W'(1);
            end
            res_next.next_pc   = pc_next;
            res_next.prog_done = pc_next >= limit_len;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.next_pc        = res_reg.next_pc;
    assign rsp.prog_done      = res_reg.prog_done;
    assign rsp.print_valid    = res_reg.print_valid;
    assign rsp.print_from_reg = res_reg.print_from_reg;
    assign rsp.print_reg      = res_reg.print_reg;
    assign rsp.print_value    = res_reg.print_value;
    assign rsp.error_code     = res_reg.error_code;

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                rf_reg[i] <= '0;
            pc_reg        <= '0;
            steps_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rf_reg        <= rf_next;
            pc_reg        <= pc_next;
            steps_reg     <= steps_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/tiny_register_machine_execute_top.sv */
// Top level: one instruction beat in, one result beat out, per cycle when not stalled.
// Path: an input beat goes into the queue, then is executed into the result register.
// Throughput: one beat per cycle unless rsp stalls, set by the back end's execute step.
// Reset: asynchronous, active low; clears registers, pc, step count, halt and queue,
// program_length to 0 and step_limit to 150. No clearing pass.
// Depends on trmx_pkg, trmx_if, trmx_cfg, trmx_front, trmx_queue and trmx_back.
module tiny_register_machine_execute_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    trmx_req_if.sink     req,
    trmx_rsp_if.source   rsp
);

    trmx_pkg::cfg_t   cfg;
    trmx_pkg::instr_t push_data;
    trmx_pkg::instr_t pop_data;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;

    trmx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trmx_front u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (push_data)
    );

    trmx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_data)
    );

    trmx_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_data  (pop_data),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
